/* sv/xed_pkg.sv */
// Shared types, entity tables and helpers for the XML entity decoder.
package xed_pkg;

  localparam int ENT_COUNT      = 5;
  localparam int ENT_MAX        = 6;
  localparam int HOLD_DEPTH     = 5;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] AMP_CHAR = 8'h26;

  typedef enum logic [2:0] {
    ENT_LT,
    ENT_GT,
    ENT_AMP,
    ENT_QUOT,
    ENT_APOS
  } ent_id_t;

  typedef logic [ENT_COUNT-1:0] ent_mask_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One emit request: a prefix of an entity's text, then an optional byte.
  typedef struct packed {
    ent_id_t    ent;
    logic [2:0] pre_len;
    logic       has_tail;
    logic [7:0] tail_byte;
    logic       last;
  } emit_cmd_t;

  // Entity text, first character in the top byte, zero padded.
  localparam logic [ENT_MAX*8-1:0] ENT_STR [ENT_COUNT] = '{
    {"&lt;", 16'h0000},
    {"&gt;", 16'h0000},
    {"&amp;", 8'h00},
    "&quot;",
    "&apos;"
  };

  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6};

  localparam logic [7:0] ENT_GLYPH [ENT_COUNT] = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27};

  function automatic logic [7:0] ent_char(ent_id_t id, logic [2:0] pos);
    logic [ENT_MAX*8-1:0] s;
    logic [7:0]           c;
    c = 8'h00;
    if (int'(id) < ENT_COUNT && int'(pos) < ENT_MAX) begin
      s = ENT_STR[id];
      c = s[8*(ENT_MAX-1-int'(pos)) +: 8];
    end
    return c;
  endfunction

  function automatic logic [2:0] ent_len(ent_id_t id);
    logic [2:0] l;
    l = 3'd0;
    if (int'(id) < ENT_COUNT) begin
      l = ENT_LEN[id];
    end
    return l;
  endfunction

  function automatic logic [7:0] ent_glyph(ent_id_t id);
    logic [7:0] g;
    g = 8'h00;
    if (int'(id) < ENT_COUNT) begin
      g = ENT_GLYPH[id];
    end
    return g;
  endfunction

  // Lowest-numbered entity whose bit is set.
  function automatic ent_id_t first_ent(ent_mask_t m);
    ent_id_t r;
    r = ENT_LT;
    for (int i = ENT_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = ent_id_t'(i);
      end
    end
    return r;
  endfunction

endpackage

/* sv/xed_front.sv */
// Front end: tracks the partial entity match and turns each byte into emit requests.
module xed_front
  import xed_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_item_t  item,
  output logic      push,
  output emit_cmd_t cmd
);

  logic [2:0] held_n;
  logic [2:0] held_n_next;
  ent_mask_t  held_mask;
  ent_mask_t  held_mask_next;

  ent_mask_t  new_mask;
  ent_mask_t  full_hit;
  ent_mask_t  prefix_hit;
  logic [7:0] b;
  logic       last;
  ent_id_t    held_ent;

  assign b    = item.in_byte;
  assign last = item.in_last;
  assign held_ent = first_ent(held_mask);

  always_comb begin
    for (int i = 0; i < ENT_COUNT; i++) begin
      new_mask[i]   = held_mask[i] && (ENT_LEN[i] > held_n) &&
                      (ent_char(ent_id_t'(i), held_n) == b);
      full_hit[i]   = new_mask[i] && (ENT_LEN[i] == held_n + 3'd1);
      prefix_hit[i] = new_mask[i] && (ENT_LEN[i] >  held_n + 3'd1);
    end
  end

  always_comb begin
    held_n_next    = held_n;
    held_mask_next = held_mask;
    cmd            = '{ent: held_ent, pre_len: 3'd0, has_tail: 1'b0,
                       tail_byte: b, last: last};
    if (held_n == 3'd0) begin
      if (b == AMP_CHAR) begin
        held_n_next    = 3'd1;
        held_mask_next = '1;
        cmd.ent        = ENT_LT;
        // flush the lone '&' at the end of text
        cmd.pre_len    = last ? 3'd1 : 3'd0;
      end else begin
        cmd.has_tail = 1'b1;
      end
    end else if (|full_hit) begin
      held_n_next    = 3'd0;
      cmd.has_tail   = 1'b1;
      cmd.tail_byte  = ent_glyph(first_ent(full_hit));
    end else if (|prefix_hit) begin
      held_n_next    = held_n + 3'd1;
      held_mask_next = new_mask;
      if (last) begin
        cmd.ent     = first_ent(new_mask);
        cmd.pre_len = held_n + 3'd1;
      end
    end else begin
      // mismatch: release the held prefix, then treat the byte afresh
      cmd.pre_len = held_n;
      if (b == AMP_CHAR && !last) begin
        held_n_next    = 3'd1;
        held_mask_next = '1;
      end else begin
        held_n_next  = 3'd0;
        cmd.has_tail = 1'b1;
      end
    end
    if (last) begin
      held_n_next = 3'd0;
    end
  end

  assign push = take && ((cmd.pre_len != 3'd0) || cmd.has_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_n <= 3'd0;
    end else if (take) begin
      held_n <= held_n_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_mask <= held_mask_next;
    end
  end

endmodule

/* sv/xed_queue.sv */
// Short request queue between front end and back end.
module xed_queue
  import xed_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  emit_cmd_t push_cmd,
  input  logic      pop,
  output emit_cmd_t head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  emit_cmd_t      slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign empty   = (count == CW'(0));
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* sv/xed_back.sv */
// Back end: expands each emit request into output bytes, one per cycle unless dst_ready stalls the output.
module xed_back
  import xed_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  emit_cmd_t head,
  input  logic      empty,
  output logic      pop,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_item_t dst_data
);

  logic [2:0] pos;
  logic [2:0] total;
  logic       final_byte;
  logic       advance;
  logic [7:0] cur_byte;

  assign total      = head.pre_len + {2'b00, head.has_tail};
  assign final_byte = (pos == total - 3'd1);
  assign advance    = !dst_valid || dst_ready;
  assign pop        = advance && !empty && final_byte;
  assign cur_byte   = (pos < head.pre_len) ? ent_char(head.ent, pos) : head.tail_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (advance) begin
      dst_valid <= !empty;
      if (!empty) begin
        pos <= final_byte ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      dst_data.out_byte <= cur_byte;
      dst_data.out_last <= head.last && final_byte;
    end
  end

endmodule

/* sv/xml_entity_decoder.sv */
// Top level of the XML predefined-entity decoder.
// Decodes the five predefined XML entities (&lt; &gt; &amp; &quot; &apos;) in a byte
// stream and passes every other byte through. The front end takes one request byte
// per cycle whenever the internal request queue has room, tracks a partial match of
// up to five bytes and hands the back end an emit request: a prefix of an entity's
// text to release, an optional following byte, and the end-of-text mark. The back
// end writes one byte per cycle into the output register while dst_ready allows, so
// an input item yields between zero and six output bytes; a mismatch after a long
// partial match (up to six bytes out) is what stalls the input, once the queue of
// QUEUE_DEPTH requests fills. Since output never outgrows input on ordinary text,
// a steady one byte per cycle is sustained while dst_ready stays high. An accepted
// byte is registered in a queue slot, then in the output register. A partial match
// held when in_last arrives is flushed unchanged, and out_last marks the flush's final byte.
module xml_entity_decoder
  import xed_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  in_item_t  src_data,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_item_t dst_data
);

  logic      take;
  logic      push;
  emit_cmd_t push_cmd;
  emit_cmd_t head;
  logic      q_empty;
  logic      q_full;
  logic      pop;

  // Hold the input whenever the queue cannot take another request.
  assign src_ready = !q_full;
  assign take      = src_valid && src_ready;

  xed_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (src_data),
    .push (push),
    .cmd  (push_cmd)
  );

  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  xed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

`ifndef SYNTH
  // A request must never be dropped on a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("emit request pushed into a full queue");

  // End of text always produces at least one output byte.
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (take && src_data.in_last) |-> (push && push_cmd.last))
    else $error("end of text produced no emit request");

  // A released prefix never exceeds the hold buffer.
  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_cmd.pre_len <= 3'(HOLD_DEPTH)))
    else $error("emit request prefix longer than hold buffer");
`endif

endmodule
